// ===== hw/rtl/tlp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlp_pkg
// Shared types and constants for the Telnet control-line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tlp_pkg;

  localparam int unsigned LineCntW = 16;
  localparam logic [LineCntW-1:0] MaxLineCharsReset = 16'd255;

  // Byte codes
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_WILL = 8'd251;
  localparam logic [7:0] CH_WONT = 8'd252;
  localparam logic [7:0] CH_DO   = 8'd253;
  localparam logic [7:0] CH_DONT = 8'd254;
  localparam logic [7:0] CH_IAC  = 8'd255;

  // Result event codes
  localparam logic [2:0] EV_DATA      = 3'd0;
  localparam logic [2:0] EV_CRLF      = 3'd1;
  localparam logic [2:0] EV_RAWLF     = 3'd2;
  localparam logic [2:0] EV_EOS       = 3'd3;
  localparam logic [2:0] EV_SEND_DONT = 3'd4;
  localparam logic [2:0] EV_SEND_WONT = 3'd5;

  typedef enum logic [2:0] {
    PH_TEXT        = 3'd0,
    PH_CR          = 3'd1,
    PH_IAC         = 3'd2,
    PH_OPT_REFUSE  = 3'd3,
    PH_OPT_DECLINE = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_stream;
  } tlp_in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] value;
  } tlp_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlp_in_stage.sv =====
// ----------------------------------------------------------------------------
// tlp_in_stage
// Input register: captures one request and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tlp_in_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire tlp_pkg::tlp_in_t in_item_i,
  input  wire logic             advance_i,
  output logic                  item_valid_o,
  output tlp_pkg::tlp_in_t      item_o
);

  logic             vld_q, vld_d;
  tlp_pkg::tlp_in_t item_q;
  logic             take;

  // Stall only while a held request cannot move on this cycle.
  assign in_stall_o = vld_q & ~advance_i;
  assign take       = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tlp_parse_core.sv =====
// ----------------------------------------------------------------------------
// tlp_parse_core
// Parse phase machine, line counter and line-length limit register.
// Produces at most one result per consumed request.
// ----------------------------------------------------------------------------
`default_nettype none

module tlp_parse_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tlp_pkg::LineCntW-1:0]  cfg_wdata_i,
  input  wire logic                          step_i,
  input  wire tlp_pkg::tlp_in_t              item_i,
  output logic                               res_valid_o,
  output tlp_pkg::tlp_out_t                  res_o
);

  tlp_pkg::phase_e                 phase_q, phase_d;
  logic [tlp_pkg::LineCntW-1:0]    cnt_q, cnt_d;
  logic [tlp_pkg::LineCntW-1:0]    max_q;

  logic [7:0] b;
  logic       eos;
  logic       is_cr, is_lf, is_nul, is_iac, is_will_wont, is_do_dont;
  logic       room;

  assign b            = item_i.rx_byte;
  assign eos          = item_i.end_of_stream;
  assign is_cr        = (b == tlp_pkg::CH_CR);
  assign is_lf        = (b == tlp_pkg::CH_LF);
  assign is_nul       = (b == tlp_pkg::CH_NUL);
  assign is_iac       = (b == tlp_pkg::CH_IAC);
  assign is_will_wont = (b == tlp_pkg::CH_WILL) || (b == tlp_pkg::CH_WONT);
  assign is_do_dont   = (b == tlp_pkg::CH_DO) || (b == tlp_pkg::CH_DONT);
  assign room         = (cnt_q < max_q);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      if (eos) begin
        phase_d = tlp_pkg::PH_TEXT;
      end else begin
        unique case (phase_q)
          tlp_pkg::PH_CR: begin
            // A second CR keeps us waiting after CR.
            if (is_cr) begin
              phase_d = tlp_pkg::PH_CR;
            end else if (is_iac && !is_nul) begin
              phase_d = tlp_pkg::PH_IAC;
            end else begin
              phase_d = tlp_pkg::PH_TEXT;
            end
          end
          tlp_pkg::PH_IAC: begin
            if (is_will_wont) begin
              phase_d = tlp_pkg::PH_OPT_REFUSE;
            end else if (is_do_dont) begin
              phase_d = tlp_pkg::PH_OPT_DECLINE;
            end else begin
              phase_d = tlp_pkg::PH_TEXT;
            end
          end
          tlp_pkg::PH_OPT_REFUSE,
          tlp_pkg::PH_OPT_DECLINE: begin
            phase_d = tlp_pkg::PH_TEXT;
          end
          default: begin
            if (is_cr) begin
              phase_d = tlp_pkg::PH_CR;
            end else if (is_iac) begin
              phase_d = tlp_pkg::PH_IAC;
            end else begin
              phase_d = tlp_pkg::PH_TEXT;
            end
          end
        endcase
      end
    end
  end

  // Result and line counter
  always_comb begin
    logic       data_sel;
    logic [7:0] data_b;
    logic       line_end;
    logic [2:0] end_ev;

    data_sel    = 1'b0;
    data_b      = b;
    line_end    = 1'b0;
    end_ev      = tlp_pkg::EV_EOS;
    res_valid_o = 1'b0;
    res_o       = '0;
    cnt_d       = cnt_q;

    if (eos) begin
      line_end = 1'b1;
      end_ev   = tlp_pkg::EV_EOS;
    end else begin
      unique case (phase_q)
        tlp_pkg::PH_CR: begin
          if (is_lf) begin
            line_end = 1'b1;
            end_ev   = tlp_pkg::EV_CRLF;
          end else if (is_nul) begin
            data_sel = 1'b1;
            data_b   = tlp_pkg::CH_CR;
          end else if (!is_cr && !is_iac) begin
            data_sel = 1'b1;
          end
        end
        tlp_pkg::PH_IAC: begin
          data_sel = !is_will_wont && !is_do_dont;
        end
        tlp_pkg::PH_OPT_REFUSE: begin
          res_valid_o     = 1'b1;
          res_o.event_res = tlp_pkg::EV_SEND_DONT;
          res_o.value     = b;
        end
        tlp_pkg::PH_OPT_DECLINE: begin
          res_valid_o     = 1'b1;
          res_o.event_res = tlp_pkg::EV_SEND_WONT;
          res_o.value     = b;
        end
        default: begin
          if (is_lf) begin
            line_end = 1'b1;
            end_ev   = tlp_pkg::EV_RAWLF;
          end else if (!is_cr && !is_iac) begin
            data_sel = 1'b1;
          end
        end
      endcase
    end

    if (line_end) begin
      res_valid_o     = 1'b1;
      res_o.event_res = end_ev;
      res_o.value     = '0;
      cnt_d           = '0;
    end else if (data_sel && room) begin
      res_valid_o     = 1'b1;
      res_o.event_res = tlp_pkg::EV_DATA;
      res_o.value     = data_b;
      cnt_d           = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tlp_pkg::PH_TEXT;
      cnt_q   <= '0;
      max_q   <= tlp_pkg::MaxLineCharsReset;
    end else begin
      phase_q <= phase_d;
      if (step_i) begin
        cnt_q <= cnt_d;
      end
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_eos_clears_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && eos |=> cnt_q == '0 && phase_q == tlp_pkg::PH_TEXT)
    else $error("end of stream did not clear line state");

  a_data_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.event_res == tlp_pkg::EV_DATA
    |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("data byte passed without counting");

  a_option_replies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !eos && (phase_q == tlp_pkg::PH_OPT_REFUSE ||
                       phase_q == tlp_pkg::PH_OPT_DECLINE) |-> res_valid_o)
    else $error("option byte gave no reply");

  a_will_to_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !eos && phase_q == tlp_pkg::PH_IAC && is_will_wont
    |=> phase_q == tlp_pkg::PH_OPT_REFUSE)
    else $error("WILL/WONT after IAC not tracked");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tlp_out_stage.sv =====
// ----------------------------------------------------------------------------
// tlp_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tlp_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic              res_valid_i,
  input  wire tlp_pkg::tlp_out_t res_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output tlp_pkg::tlp_out_t      out_item_o
);

  logic              vld_q, vld_d;
  tlp_pkg::tlp_out_t item_q;
  logic              load;

  // Register is free when empty or being drained this cycle.
  assign free_o = ~vld_q | ~out_stall_i;
  assign load   = step_i & res_valid_i;

  always_comb begin
    vld_d = vld_q;
    if (free_o) begin
      vld_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/telnet_control_line_parser.sv =====
// ----------------------------------------------------------------------------
// telnet_control_line_parser
// Splits a Telnet control byte stream into lines, refuses option offers
// and enforces a per-line length limit.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in      | request   | in_valid_i / in_stall_o | in_item_i  (tlp_in_t)
//   out     | result    | out_valid_o / out_stall_i | out_item_o (tlp_out_t)
//   cfg     | write     | cfg_we_i               | cfg_wdata_i (max_line_chars)
//
// One request per cycle while the result side is not stalled; a request passes
// from the input register through the parse step into the result register.
// The parse step is a phase decode plus one 16-bit compare and increment.
// Reset clears the phase, the line counter and the valid flags and sets
// the line limit to 255. A stall on the result side holds the result
// register, then the input register, then stalls the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module telnet_control_line_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire tlp_pkg::tlp_in_t             in_item_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output tlp_pkg::tlp_out_t                 out_item_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [tlp_pkg::LineCntW-1:0] cfg_wdata_i
);

  logic              item_valid;
  tlp_pkg::tlp_in_t  item;
  logic              out_free;
  logic              step;
  logic              res_valid;
  tlp_pkg::tlp_out_t res;

  assign step = item_valid & out_free;

  tlp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .advance_i    (step),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  tlp_parse_core u_parse_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tlp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== tb/telnet_control_line_parser_tb.sv =====
// ----------------------------------------------------------------------------
// telnet_control_line_parser_tb
// Self-checking bench for the Telnet control-line parser. Control bytes go
// in through the request channel, and a local parser model computes the
// event each byte should raise. Checked areas are line ends, CR handling,
// option refusal, end of stream and the per-line length limit. Random
// traffic then runs under several line limits and backpressure patterns.
// ----------------------------------------------------------------------------
module telnet_control_line_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = 4;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  tlp_pkg::tlp_in_t             in_item_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  tlp_pkg::tlp_out_t            out_item_o;
  logic                         cfg_we_i;
  logic [tlp_pkg::LineCntW-1:0] cfg_wdata_i;

  // Parser model state
  tlp_pkg::phase_e              pred_phase;
  logic [tlp_pkg::LineCntW-1:0] pred_line_chars;
  logic [tlp_pkg::LineCntW-1:0] pred_line_limit;

  tlp_pkg::tlp_out_t expected_events[$];
  tlp_pkg::tlp_out_t next_event;
  int                n_fail;
  int                n_sent;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                cycle_cnt;

  telnet_control_line_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function automatic bit close_line(input logic [2:0] ev,
                                    output tlp_pkg::tlp_out_t res);
    pred_phase      = tlp_pkg::PH_TEXT;
    pred_line_chars = '0;
    res.event_res   = ev;
    res.value       = 8'h00;
    return 1'b1;
  endfunction

  function automatic bit pass_data(input logic [7:0] b,
                                   output tlp_pkg::tlp_out_t res);
    pred_phase    = tlp_pkg::PH_TEXT;
    res.event_res = tlp_pkg::EV_DATA;
    res.value     = b;
    if (pred_line_chars < pred_line_limit) begin
      pred_line_chars = pred_line_chars + 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit text_byte(input logic [7:0] b,
                                   output tlp_pkg::tlp_out_t res);
    res = '0;
    if (b == tlp_pkg::CH_CR) begin
      pred_phase = tlp_pkg::PH_CR;
      return 1'b0;
    end
    if (b == tlp_pkg::CH_LF) return close_line(tlp_pkg::EV_RAWLF, res);
    if (b == tlp_pkg::CH_IAC) begin
      pred_phase = tlp_pkg::PH_IAC;
      return 1'b0;
    end
    return pass_data(b, res);
  endfunction

  function automatic bit parse_control_byte(input tlp_pkg::tlp_in_t req,
                                            output tlp_pkg::tlp_out_t res);
    logic [7:0] b;
    b   = req.rx_byte;
    res = '0;
    if (req.end_of_stream) return close_line(tlp_pkg::EV_EOS, res);
    case (pred_phase)
      tlp_pkg::PH_CR: begin
        if (b == tlp_pkg::CH_LF) return close_line(tlp_pkg::EV_CRLF, res);
        if (b == tlp_pkg::CH_NUL) return pass_data(tlp_pkg::CH_CR, res);
        return text_byte(b, res);
      end
      tlp_pkg::PH_IAC: begin
        if (b == tlp_pkg::CH_WILL || b == tlp_pkg::CH_WONT) begin
          pred_phase = tlp_pkg::PH_OPT_REFUSE;
          return 1'b0;
        end
        if (b == tlp_pkg::CH_DO || b == tlp_pkg::CH_DONT) begin
          pred_phase = tlp_pkg::PH_OPT_DECLINE;
          return 1'b0;
        end
        return pass_data(b, res);
      end
      tlp_pkg::PH_OPT_REFUSE: begin
        pred_phase    = tlp_pkg::PH_TEXT;
        res.event_res = tlp_pkg::EV_SEND_DONT;
        res.value     = b;
        return 1'b1;
      end
      tlp_pkg::PH_OPT_DECLINE: begin
        pred_phase    = tlp_pkg::PH_TEXT;
        res.event_res = tlp_pkg::EV_SEND_WONT;
        res.value     = b;
        return 1'b1;
      end
      default: return text_byte(b, res);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_request(input tlp_pkg::tlp_in_t req);
    tlp_pkg::tlp_out_t res;
    bit                emits;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      in_item_i  <= tlp_pkg::tlp_in_t'($urandom_range(511));
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    emits = parse_control_byte(req, res);
    if (emits) expected_events.push_back(res);
    n_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    tlp_pkg::tlp_in_t req;
    req.rx_byte       = b;
    req.end_of_stream = 1'b0;
    send_request(req);
  endtask

  task automatic send_eos();
    tlp_pkg::tlp_in_t req;
    req.rx_byte       = 8'($urandom_range(255));
    req.end_of_stream = 1'b1;
    send_request(req);
  endtask

  // Drop valid and hold until every expected event has come out.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_line_limit(input logic [tlp_pkg::LineCntW-1:0] limit);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    pred_line_limit = limit;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == tlp_pkg::CH_CR || b == tlp_pkg::CH_LF || b == tlp_pkg::CH_IAC);
    return b;
  endfunction

  function automatic logic [tlp_pkg::LineCntW-1:0] pick_line_limit();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return tlp_pkg::MaxLineCharsReset;
      5:       return tlp_pkg::LineCntW'($urandom_range(65535));
      default: return tlp_pkg::LineCntW'($urandom_range(8, 1));
    endcase
  endfunction

  // Mostly well-formed Telnet sequences; the tail is noise.
  task automatic send_token();
    int kind;
    kind = $urandom_range(99);
    if (kind < 40) begin
      send_byte(plain_byte());
    end else if (kind < 50) begin
      send_byte(tlp_pkg::CH_CR);
      send_byte(tlp_pkg::CH_LF);
    end else if (kind < 55) begin
      send_byte(tlp_pkg::CH_CR);
      send_byte(tlp_pkg::CH_NUL);
    end else if (kind < 60) begin
      send_byte(tlp_pkg::CH_CR);
      send_byte(8'($urandom_range(255)));
    end else if (kind < 65) begin
      send_byte(tlp_pkg::CH_LF);
    end else if (kind < 78) begin
      send_byte(tlp_pkg::CH_IAC);
      send_byte(8'($urandom_range(tlp_pkg::CH_DONT, tlp_pkg::CH_WILL)));
      send_byte(8'($urandom_range(255)));
    end else if (kind < 83) begin
      send_byte(tlp_pkg::CH_IAC);
      send_byte(8'($urandom_range(255)));
    end else if (kind < 86) begin
      send_eos();
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_text_and_line_ends();
    send_byte(8'h41);
    send_byte(tlp_pkg::CH_NUL);
    send_byte(tlp_pkg::CH_CR);
    send_byte(tlp_pkg::CH_LF);
    send_byte(tlp_pkg::CH_CR);
    send_byte(tlp_pkg::CH_NUL);
    // CR CR: drop the first, stay after CR
    send_byte(tlp_pkg::CH_CR);
    send_byte(tlp_pkg::CH_CR);
    send_byte(8'h78);
    send_byte(tlp_pkg::CH_LF);
  endtask

  task automatic test_option_refusal();
    send_byte(tlp_pkg::CH_IAC);
    send_byte(tlp_pkg::CH_WILL);
    send_byte(8'h01);
    send_byte(tlp_pkg::CH_IAC);
    send_byte(tlp_pkg::CH_WONT);
    send_byte(8'hFF);
    send_byte(tlp_pkg::CH_IAC);
    send_byte(tlp_pkg::CH_DO);
    send_byte(8'h00);
    send_byte(tlp_pkg::CH_IAC);
    send_byte(tlp_pkg::CH_DONT);
    send_byte(8'h18);
    send_byte(tlp_pkg::CH_IAC);
    send_byte(tlp_pkg::CH_IAC);
  endtask

  task automatic test_end_of_stream();
    send_byte(tlp_pkg::CH_CR);
    send_eos();
    send_byte(tlp_pkg::CH_IAC);
    send_byte(tlp_pkg::CH_WILL);
    send_eos();
  endtask

  task automatic test_line_limit();
    write_line_limit('0);
    send_byte(8'h61);
    send_byte(tlp_pkg::CH_CR);
    send_byte(tlp_pkg::CH_NUL);
    send_byte(tlp_pkg::CH_IAC);
    send_byte(tlp_pkg::CH_IAC);
    send_byte(tlp_pkg::CH_CR);
    send_byte(tlp_pkg::CH_LF);
    write_line_limit(16'd2);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(8'h63);
    send_byte(tlp_pkg::CH_LF);
    write_line_limit(tlp_pkg::MaxLineCharsReset);
    repeat (260) send_byte(plain_byte());
    send_byte(tlp_pkg::CH_CR);
    send_byte(tlp_pkg::CH_LF);
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop_at;
    int next_cfg;
    stop_at  = n_sent + n_items;
    next_cfg = n_sent;
    while (n_sent < stop_at) begin
      if (n_sent >= next_cfg) begin
        write_line_limit(pick_line_limit());
        next_cfg = n_sent + 60;
      end
      send_token();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result: event_res=%0d value=%0d",
               out_item_o.event_res, out_item_o.value);
        n_fail++;
      end else begin
        next_event = expected_events.pop_front();
        if (out_item_o.event_res !== next_event.event_res) begin
          $error("event_res mismatch: expected %0d, actual %0d",
                 next_event.event_res, out_item_o.event_res);
          n_fail++;
        end
        if (out_item_o.value !== next_event.value) begin
          $error("value mismatch: expected %0d, actual %0d",
                 next_event.value, out_item_o.value);
          n_fail++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_item_i       = '0;
    out_stall_i     = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    n_fail          = 0;
    n_sent          = 0;
    cycle_cnt       = 0;
    pred_phase      = tlp_pkg::PH_TEXT;
    pred_line_chars = '0;
    pred_line_limit = tlp_pkg::MaxLineCharsReset;
    send_idle_pct   = 25;
    recv_idle_pct   = 52;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_text_and_line_ends();
    test_option_refusal();
    test_end_of_stream();
    test_line_limit();
    test_random_traffic(330);
    send_idle_pct = 52;
    recv_idle_pct = 25;
    test_random_traffic(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(330);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
